### sv/idqr_pkg.sv
package idqr_pkg;

    localparam int W = 32;

    // Bit positions within the mode field.
    localparam int MODE_SIGNED_BIT = 0;
    localparam int MODE_REM_BIT    = 1;
    localparam int MODE_W          = 3;

    typedef logic [W-1:0] t_word;

    // Control that travels with each request down the divider chain.
    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
        logic want_rem;
        logic dbz;
    } t_ctl;

endpackage

### sv/int32_divide_quotient_remainder.sv
// 32-bit integer divider, signed or unsigned, giving quotient or remainder.
// A request is taken at a rising edge where start is high and busy is low.
// The request carries i_dividend, i_divisor and i_mode_flags: bit 0 selects
// signed division, bit 1 selects the remainder instead of the quotient, and
// bit 2 has no effect. Signed division truncates toward zero.
// Each request gives one result on o_result_word and o_divide_by_zero,
// shown for one cycle while o_done is high.
// A zero divisor gives a result of zero with o_divide_by_zero set.
// The path has one stage that forms the operand magnitudes, a chain of
// 32 cells, each retiring one quotient bit, and one stage restoring signs.
// Throughput is one request per cycle; busy stays low, since every stage of
// the chain advances in every cycle.
// Results come out in request order, and the receiver cannot stall them.
// Reset (synchronous, active low) drops every request in flight; no result
// appears for those.
module int32_divide_quotient_remainder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  idqr_pkg::t_word      i_dividend,
    input  idqr_pkg::t_word      i_divisor,
    input  logic [2:0]           i_mode_flags,
    output logic                 o_done,
    output idqr_pkg::t_word      o_result_word,
    output logic                 o_divide_by_zero
);
    import idqr_pkg::*;

    t_ctl  ctl_s [0:W];
    t_word rem_s [0:W];
    t_word dq_s  [0:W];
    t_word dvs_s [0:W];

    assign busy = 1'b0;

    idqr_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start & ~busy),
        .i_dividend   (i_dividend),
        .i_divisor    (i_divisor),
        .i_mode_flags (i_mode_flags),
        .o_ctl        (ctl_s[0]),
        .o_mag_a      (dq_s[0]),
        .o_mag_b      (dvs_s[0])
    );

    assign rem_s[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        idqr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_s[g]),
            .i_rem   (rem_s[g]),
            .i_dq    (dq_s[g]),
            .i_dvs   (dvs_s[g]),
            .o_ctl   (ctl_s[g+1]),
            .o_rem   (rem_s[g+1]),
            .o_dq    (dq_s[g+1]),
            .o_dvs   (dvs_s[g+1])
        );
    end

    idqr_fix u_fix (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl_s[W]),
        .i_rem            (rem_s[W]),
        .i_quo            (dq_s[W]),
        .o_done           (o_done),
        .o_result_word    (o_result_word),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

### sv/idqr_prep.sv
module idqr_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  idqr_pkg::t_word      i_dividend,
    input  idqr_pkg::t_word      i_divisor,
    input  logic [2:0]           i_mode_flags,
    output idqr_pkg::t_ctl       o_ctl,
    output idqr_pkg::t_word      o_mag_a,
    output idqr_pkg::t_word      o_mag_b
);
    import idqr_pkg::*;

    t_ctl  r_ctl, n_ctl;
    t_word r_mag_a, n_mag_a;
    t_word r_mag_b, n_mag_b;
    logic  na, nb;

    always_comb begin
        na = i_mode_flags[MODE_SIGNED_BIT] & i_dividend[W-1];
        nb = i_mode_flags[MODE_SIGNED_BIT] & i_divisor[W-1];
        n_mag_a = na ? (~i_dividend + t_word'(1)) : i_dividend;
        n_mag_b = nb ? (~i_divisor + t_word'(1)) : i_divisor;
        n_ctl.valid    = i_start;
        n_ctl.neg_q    = na ^ nb;
        n_ctl.neg_r    = na;
        n_ctl.want_rem = i_mode_flags[MODE_REM_BIT];
        n_ctl.dbz      = (i_divisor == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_a <= n_mag_a;
        r_mag_b <= n_mag_b;
    end

    assign o_ctl   = r_ctl;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;

endmodule

### sv/idqr_cell.sv
module idqr_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idqr_pkg::t_ctl       i_ctl,
    input  idqr_pkg::t_word      i_rem,
    input  idqr_pkg::t_word      i_dq,
    input  idqr_pkg::t_word      i_dvs,
    output idqr_pkg::t_ctl       o_ctl,
    output idqr_pkg::t_word      o_rem,
    output idqr_pkg::t_word      o_dq,
    output idqr_pkg::t_word      o_dvs
);
    import idqr_pkg::*;

    t_ctl      r_ctl;
    t_word     r_rem, n_rem;
    t_word     r_dq, n_dq;
    t_word     r_dvs;
    logic [W:0] trial, diff;
    logic      qbit;

    // One restoring step: shift in the next dividend bit and try a subtract.
    // For a nonzero divisor the partial remainder stays below it, so the trial fits W+1 bits.
    always_comb begin
        trial = {i_rem, i_dq[W-1]};
        diff  = trial - {1'b0, i_dvs};
        qbit  = ~diff[W];
        n_rem = qbit ? diff[W-1:0] : trial[W-1:0];
        n_dq  = {i_dq[W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_dvs <= i_dvs;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_dq  = r_dq;
    assign o_dvs = r_dvs;

endmodule

### sv/idqr_fix.sv
module idqr_fix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idqr_pkg::t_ctl       i_ctl,
    input  idqr_pkg::t_word      i_rem,
    input  idqr_pkg::t_word      i_quo,
    output logic                 o_done,
    output idqr_pkg::t_word      o_result_word,
    output logic                 o_divide_by_zero
);
    import idqr_pkg::*;

    logic  r_done;
    t_word r_result, n_result;
    logic  r_dbz;
    t_word sel;
    logic  neg;

    always_comb begin
        sel = i_ctl.want_rem ? i_rem : i_quo;
        neg = i_ctl.want_rem ? i_ctl.neg_r : i_ctl.neg_q;
        if (i_ctl.dbz) begin
            n_result = '0;
        end else if (neg) begin
            n_result = ~sel + t_word'(1);
        end else begin
            n_result = sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_dbz    <= i_ctl.dbz;
    end

    assign o_done           = r_done;
    assign o_result_word    = r_result;
    assign o_divide_by_zero = r_dbz;

endmodule
